// ----- hw/rtl/mhpq_pkg.sv -----
package mhpq_pkg;

  // width of one stored entry
  localparam int unsigned DataW = 32;
  // width of the reported entry count
  localparam int unsigned CountOutW = 11;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LAST,
    ST_DN_RD,
    ST_DN_CMP
  } state_t;

endpackage

// ----- hw/rtl/min_heap_priority_queue_core.sv -----
// binary min-heap of signed 32-bit values, up to CAPACITY entries
// request channel: action and value are taken at a rising edge with start high
// and busy low; action 0 inserts value, action 1 pops the minimum
// result channel: done is high for exactly one cycle per request; popped_value,
// top_value, entry_count and status are valid in that cycle only
// the receiver cannot stall, so a result is simply presented and gone
// an insert climbs at most log2(CAPACITY) levels, until its parent is not
// larger or it reaches the root; a pop fetches the last entry, then sinks it
// from the root until no child is smaller or it reaches a leaf; a pop on an
// empty heap, a pop of the last entry and an insert into a full heap report
// straight from the idle state
// each level takes a read state and a compare/write state of the entry store,
// which is held twice so that both children of a node are read together
// busy is high while a request is in flight; a new request may be given in the
// very cycle in which done is high
// reset empties the heap (count to zero); the entry store keeps its contents
// but nothing beyond the count is ever read
module min_heap_priority_queue_core #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic signed [31:0] value,
  output logic               done,
  output logic signed [31:0] popped_value,
  output logic signed [31:0] top_value,
  output logic [10:0]        entry_count,
  output logic [1:0]         status
);

  // slot numbers run 1..CAPACITY, memory addresses 0..CAPACITY-1
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned DW = mhpq_pkg::DataW;
  localparam int unsigned OW = mhpq_pkg::CountOutW;

  mhpq_pkg::state_t  state, state_next;
  mhpq_pkg::status_t res_status, res_status_next;

  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        pos, pos_next;       // current hole position (slot)
  logic signed [DW-1:0] mov, mov_next;       // value being sifted
  logic signed [DW-1:0] top;                 // copy of slot 1
  logic signed [DW-1:0] popped, popped_next;
  logic                 right_ok, right_ok_next;
  logic                 done_next;

  // store access
  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [DW-1:0] rdata_a, rdata_b;

  // helper values
  logic [CW:0]          left_slot;
  logic [CW-1:0]        up_slot;
  logic signed [DW-1:0] kid_val;
  logic [CW-1:0]        kid_slot;
  logic [CW+OW-1:0]     count_ext;

  assign left_slot = {pos, 1'b0};
  assign up_slot   = pos >> 1;

  // two copies of the store, written together, read at left and right child
  mhpq_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mhpq_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // smaller child, left on a tie
  always_comb begin
    if (right_ok && ($signed(rdata_b) < $signed(rdata_a))) begin
      kid_val  = $signed(rdata_b);
      kid_slot = CW'(left_slot + 1'b1);
    end else begin
      kid_val  = $signed(rdata_a);
      kid_slot = CW'(left_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpq_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    mov        <= mov_next;
    popped     <= popped_next;
    res_status <= res_status_next;
    right_ok   <= right_ok_next;
    if (we && (waddr == '0)) begin
      top <= $signed(wdata);
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    mov_next        = mov;
    popped_next     = popped;
    res_status_next = res_status;
    right_ok_next   = right_ok;
    done_next       = 1'b0;
    we              = 1'b0;
    waddr           = AW'(pos - 1'b1);
    wdata           = mov;
    raddr_a         = AW'(up_slot - 1'b1);
    raddr_b         = AW'(left_slot);

    unique case (state)
      mhpq_pkg::ST_IDLE: begin
        if (start) begin
          popped_next     = '0;
          res_status_next = mhpq_pkg::STATUS_OK;
          if (!action) begin
            if (count == CW'(CAPACITY)) begin
              // full: drop the value
              res_status_next = mhpq_pkg::STATUS_FULL;
              done_next       = 1'b1;
            end else begin
              count_next = count + 1'b1;
              pos_next   = count + 1'b1;
              mov_next   = value;
              state_next = mhpq_pkg::ST_UP_RD;
            end
          end else begin
            if (count == '0) begin
              res_status_next = mhpq_pkg::STATUS_EMPTY;
              done_next       = 1'b1;
            end else if (count == CW'(1)) begin
              // last entry leaves, nothing to move
              popped_next = top;
              count_next  = '0;
              done_next   = 1'b1;
            end else begin
              // fetch the last entry to refill the root
              popped_next = top;
              raddr_a     = AW'(count - 1'b1);
              count_next  = count - 1'b1;
              pos_next    = CW'(1);
              state_next  = mhpq_pkg::ST_DN_LAST;
            end
          end
        end
      end

      mhpq_pkg::ST_UP_RD: begin
        if (pos == CW'(1)) begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = mhpq_pkg::ST_IDLE;
        end else begin
          raddr_a    = AW'(up_slot - 1'b1);
          state_next = mhpq_pkg::ST_UP_CMP;
        end
      end

      mhpq_pkg::ST_UP_CMP: begin
        we = 1'b1;
        if (mov < $signed(rdata_a)) begin
          // parent moves down into the hole
          wdata      = rdata_a;
          pos_next   = up_slot;
          state_next = mhpq_pkg::ST_UP_RD;
        end else begin
          done_next  = 1'b1;
          state_next = mhpq_pkg::ST_IDLE;
        end
      end

      mhpq_pkg::ST_DN_LAST: begin
        mov_next   = $signed(rdata_a);
        state_next = mhpq_pkg::ST_DN_RD;
      end

      mhpq_pkg::ST_DN_RD: begin
        if (left_slot > {1'b0, count}) begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = mhpq_pkg::ST_IDLE;
        end else begin
          raddr_a       = AW'(left_slot - 1'b1);
          right_ok_next = (left_slot + 1'b1) <= {1'b0, count};
          // keep the right read in range when there is no right child
          raddr_b       = right_ok_next ? AW'(left_slot) : AW'(left_slot - 1'b1);
          state_next    = mhpq_pkg::ST_DN_CMP;
        end
      end

      mhpq_pkg::ST_DN_CMP: begin
        we = 1'b1;
        if (kid_val < mov) begin
          // smaller child moves up into the hole
          wdata      = kid_val;
          pos_next   = kid_slot;
          state_next = mhpq_pkg::ST_DN_RD;
        end else begin
          done_next  = 1'b1;
          state_next = mhpq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = mhpq_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy         = (state != mhpq_pkg::ST_IDLE);
  assign popped_value = popped;
  assign top_value    = (count != '0) ? top : '0;
  assign count_ext    = {{OW{1'b0}}, count};
  assign entry_count  = count_ext[OW-1:0];
  assign status       = res_status;

`ifndef NO_ASSERTIONS
  // an accepted request either reports at once or keeps the block busy
  a_start_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither busy nor done");

  // a result only appears once the walk has ended
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while still busy");

  // count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // a dropped insert only happens on a full heap
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (done && (res_status == mhpq_pkg::STATUS_FULL)) |-> (count == CW'(CAPACITY)))
    else $error("insert dropped on a heap that was not full");

  // an empty pop leaves the heap empty
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (done && (res_status == mhpq_pkg::STATUS_EMPTY)) |-> (count == '0))
    else $error("empty pop reported on a non-empty heap");
`endif

endmodule

// ----- hw/rtl/mhpq_ram.sv -----
module mhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
